// ----- hw/rtl/cdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and helpers for the circular deque
// Sizes, action and status codes, controller states and slot index helpers.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CAP_W      = $clog2(DEPTH + 1);
	localparam int ACTION_W   = 2;
	localparam int STATUS_W   = 2;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CAP_W-1:0]      cap_t;
	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_BACK  = 2'd0,
		ACT_PUSH_FRONT = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_BACK   = 2'd3
	} action_e;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2
	} status_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOAD
	} state_e;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;  // capture the accepted item
		logic exec;     // update indices, access storage
		logic load_out; // fill the output register
		logic cfg_wr;   // write capacity and empty the queue
	} cmd_t;

	localparam cap_t CAP_RESET = cap_t'(DEPTH);

	// Slot after i, wrapping at the capacity in use
	function automatic idx_t next_slot(idx_t i, cap_t cap);
		cap_t inc;
		inc = cap_t'(i) + cap_t'(1);
		return (inc >= cap) ? '0 : idx_t'(inc);
	endfunction

	// Slot before i, wrapping at the capacity in use
	function automatic idx_t prev_slot(idx_t i, cap_t cap);
		cap_t last;
		last = cap - cap_t'(1);
		return (i == '0) ? idx_t'(last) : i - idx_t'(1);
	endfunction

endpackage

// ----- hw/rtl/cdq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ctrl: sequencing controller for the circular deque
// Accepts one item, runs the execute and output load steps, and owns the
// output valid flag and the configuration handshake.
// ----------------------------------------------------------------------------
module cdq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	output cdq_pkg::cmd_t cmd
);
	import cdq_pkg::*;

	state_e state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// Output register can take a new result this cycle
	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: state_d = ST_LOAD;
			ST_LOAD: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall     = 1'b0;
				cfg_ready    = 1'b1;
				cmd.load_in  = in_valid;
				cmd.cfg_wr   = cfg_valid;
			end
			ST_EXEC: cmd.exec = 1'b1;
			ST_LOAD: cmd.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// transfer drains the register unless a new result lands
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/cdq_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_dp: datapath of the circular deque
// Capacity, head/tail indices, free count, the storage memory and the
// output register.
// ----------------------------------------------------------------------------
module cdq_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cdq_pkg::cmd_t                       cmd,
	input  logic [cdq_pkg::ACTION_W-1:0]        action,
	input  logic signed [cdq_pkg::DATA_WIDTH-1:0] value,
	input  logic [cdq_pkg::CAP_W-1:0]           cfg_data,
	output logic signed [cdq_pkg::DATA_WIDTH-1:0] popped_value,
	output logic [cdq_pkg::STATUS_W-1:0]        status,
	output logic [cdq_pkg::CAP_W-1:0]           entries_held
);
	import cdq_pkg::*;

	data_t   mem [DEPTH];

	action_e act_q;
	data_t   data_q;
	cap_t    cap_q;
	idx_t    head_q, tail_q;
	cap_t    free_q;
	data_t   rd_data_q;
	status_e sts_q;
	logic    pop_ok_q;
	data_t   popped_q;
	status_e status_q;
	cap_t    held_q;

	idx_t    head_d, tail_d, wr_addr, rd_addr;
	cap_t    free_d, free_inc, cap_clamp;
	status_e sts_d;
	logic    we, pop_ok;

	// Clamp the written capacity to 1..DEPTH
	always_comb begin
		cap_clamp = cfg_data;
		if (cfg_data == '0) cap_clamp = cap_t'(1);
		else if (cfg_data > CAP_RESET) cap_clamp = CAP_RESET;
	end

	// Action decode and index update
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		free_d   = free_q;
		free_inc = free_q + cap_t'(1);
		wr_addr  = tail_q;
		rd_addr  = head_q;
		we       = 1'b0;
		pop_ok   = 1'b0;
		sts_d    = STS_OK;
		unique case (act_q)
			ACT_PUSH_BACK: begin
				if (free_q == '0) sts_d = STS_FULL;
				else begin
					tail_d  = next_slot(tail_q, cap_q);
					wr_addr = tail_d;
					we      = 1'b1;
					free_d  = free_q - cap_t'(1);
				end
			end
			ACT_PUSH_FRONT: begin
				if (free_q == '0) sts_d = STS_FULL;
				else begin
					head_d  = prev_slot(head_q, cap_q);
					wr_addr = head_d;
					we      = 1'b1;
					free_d  = free_q - cap_t'(1);
				end
			end
			ACT_POP_FRONT: begin
				if (free_q >= cap_q) sts_d = STS_EMPTY;
				else begin
					rd_addr = head_q;
					head_d  = next_slot(head_q, cap_q);
					pop_ok  = 1'b1;
					free_d  = free_inc;
				end
			end
			ACT_POP_BACK: begin
				if (free_q >= cap_q) sts_d = STS_EMPTY;
				else begin
					rd_addr = tail_q;
					tail_d  = prev_slot(tail_q, cap_q);
					pop_ok  = 1'b1;
					free_d  = free_inc;
				end
			end
			default: ;
		endcase
		// last entry popped: indices back to their start
		if (pop_ok && free_inc >= cap_q) begin
			head_d = '0;
			tail_d = idx_t'(cap_q - cap_t'(1));
			free_d = cap_q;
		end
	end

	// Control state: capacity, indices, free count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			head_q <= '0;
			tail_q <= idx_t'(CAP_RESET - cap_t'(1));
			free_q <= CAP_RESET;
		end else if (cmd.cfg_wr) begin
			cap_q  <= cap_clamp;
			head_q <= '0;
			tail_q <= idx_t'(cap_clamp - cap_t'(1));
			free_q <= cap_clamp;
		end else if (cmd.exec) begin
			head_q <= head_d;
			tail_q <= tail_d;
			free_q <= free_d;
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q  <= action_e'(action);
			data_q <= value;
		end
	end

	// Storage: at most one write and one registered read per item
	always_ff @(posedge clk) begin
		if (cmd.exec && we) mem[wr_addr] <= data_q;
		if (cmd.exec) rd_data_q <= mem[rd_addr];
	end

	// Execute results held for the output load
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			sts_q    <= sts_d;
			pop_ok_q <= pop_ok;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			popped_q <= pop_ok_q ? rd_data_q : '0;
			status_q <= sts_q;
			held_q   <= cap_q - free_q;
		end
	end

	assign popped_value = popped_q;
	assign status       = status_q;
	assign entries_held = held_q;

endmodule

// ----- hw/rtl/circular_deque_top.sv -----
`timescale 1ns / 1ps
// Each item is accepted, then executed with one storage write or read, then its result is loaded
// into the output register; the output load waits while the output register stays stalled,
// and no new item is accepted until that load is done.
// Reset: arst_n clears capacity to 64, empties the queue and drops out_valid;
// storage contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// circular_deque_top: double-ended queue in a circular store
// Push/pop at either end; one result per item with value, status and fill.
// ----------------------------------------------------------------------------
module circular_deque_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [cdq_pkg::ACTION_W-1:0]          action,
	input  logic signed [cdq_pkg::DATA_WIDTH-1:0] value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [cdq_pkg::DATA_WIDTH-1:0] popped_value,
	output logic [cdq_pkg::STATUS_W-1:0]          status,
	output logic [cdq_pkg::CAP_W-1:0]             entries_held,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cdq_pkg::CAP_W-1:0]             cfg_data
);
	import cdq_pkg::*;

	cmd_t cmd;

	// Sequencer
	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	// Indices, storage and output register
	cdq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.action       (action),
		.value        (value),
		.cfg_data     (cfg_data),
		.popped_value (popped_value),
		.status       (status),
		.entries_held (entries_held)
	);

endmodule
